@@ hdl/tsd_pkg.sv @@
package tsd_pkg;

    localparam int POS_W      = 16;
    localparam int PWR_W      = 7;
    localparam int PEAK_W     = 8;
    localparam int PROD_W     = 23;
    localparam int FAC_W      = 11;
    localparam int REM_W      = 34;
    localparam int Q_W        = 11;
    localparam int DRV_W      = 12;
    localparam int PHASE_W    = 2;
    localparam int CNT_W      = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int FAC_NOM    = 1000;
    localparam int FAC_LO     = 900;
    localparam int FAC_HI     = 1100;
    localparam int DEN_SCALE  = 100;

    localparam logic [PWR_W-1:0] PWR_MAX         = PWR_W'(100);
    localparam logic [PWR_W-1:0] START_POWER_RST = PWR_W'(20);
    localparam logic [PWR_W-1:0] END_POWER_RST   = PWR_W'(20);

    localparam logic [PHASE_W-1:0] PH_ACCEL  = 2'd0;
    localparam logic [PHASE_W-1:0] PH_CRUISE = 2'd1;
    localparam logic [PHASE_W-1:0] PH_DECEL  = 2'd2;
    localparam logic [PHASE_W-1:0] PH_STOP   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_START_POWER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_END_POWER   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RAMP_UP     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RAMP_DOWN   = 2'd3;

    typedef struct packed {
        logic [PWR_W-1:0] start_power;
        logic [PWR_W-1:0] end_power;
        logic [POS_W-1:0] ramp_up_length;
        logic [POS_W-1:0] ramp_down_length;
    } t_cfg;

    typedef struct packed {
        logic start;
        logic tick_load;
        logic eval;
        logic mul;
        logic sum;
        logic scale;
        logic div_step;
        logic hold_first;
        logic emit;
        logic emit_stop;
        logic chan;
    } t_cmd;

    typedef struct packed {
        logic active;
        logic goal_reached;
        logic out_free;
    } t_status;

    function automatic logic [PWR_W-1:0] sat_pwr(input logic [PEAK_W-1:0] p);
        logic [PWR_W-1:0] r;
        r = (p > PEAK_W'(PWR_MAX)) ? PWR_MAX : p[PWR_W-1:0];
        return r;
    endfunction

endpackage

@@ hdl/tsd_if.sv @@
interface tsd_in_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 kind;
    logic        [tsd_pkg::POS_W-1:0]     target_distance;
    logic signed [tsd_pkg::PEAK_W-1:0]    peak_power;
    logic        [tsd_pkg::POS_W-1:0]     left_position;
    logic        [tsd_pkg::POS_W-1:0]     right_position;

    modport source (
        output valid, kind, target_distance, peak_power, left_position, right_position,
        input  ready
    );
    modport sink (
        input  valid, kind, target_distance, peak_power, left_position, right_position,
        output ready
    );
endinterface

interface tsd_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [tsd_pkg::DRV_W-1:0]     first_drive;
    logic signed [tsd_pkg::DRV_W-1:0]     second_drive;
    logic                                 stopped;
    logic        [tsd_pkg::PHASE_W-1:0]   phase;

    modport source (
        output valid, first_drive, second_drive, stopped, phase,
        input  ready
    );
    modport sink (
        input  valid, first_drive, second_drive, stopped, phase,
        output ready
    );
endinterface

interface tsd_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [tsd_pkg::CFG_IDX_W-1:0]        index;
    logic [tsd_pkg::CFG_DATA_W-1:0]       data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ hdl/tsd_regs.sv @@
module tsd_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tsd_cfg_if.sink       i_cfg,
    output tsd_pkg::t_cfg o_cfg
);
    import tsd_pkg::*;

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_power      <= START_POWER_RST;
            r_cfg.end_power        <= END_POWER_RST;
            r_cfg.ramp_up_length   <= '0;
            r_cfg.ramp_down_length <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_START_POWER: r_cfg.start_power      <= i_cfg.data[PWR_W-1:0];
                REG_END_POWER:   r_cfg.end_power        <= i_cfg.data[PWR_W-1:0];
                REG_RAMP_UP:     r_cfg.ramp_up_length   <= i_cfg.data[POS_W-1:0];
                REG_RAMP_DOWN:   r_cfg.ramp_down_length <= i_cfg.data[POS_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

@@ hdl/tsd_ctrl.sv @@
module tsd_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_kind,
    input  tsd_pkg::t_status i_status,
    output logic             o_in_ready,
    output tsd_pkg::t_cmd    o_cmd
);
    import tsd_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EVAL,
        S_STOP,
        S_MUL,
        S_SUM,
        S_SCALE,
        S_DIV,
        S_NEXT,
        S_EMIT
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_chan, n_chan;
    t_cmd             cmd;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_chan  = r_chan;
        cmd     = '0;
        cmd.chan = r_chan;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (!i_in_kind) begin
                        cmd.start = 1'b1;
                    end else if (i_status.active) begin
                        cmd.tick_load = 1'b1;
                        n_state = S_EVAL;
                    end
                end
            end
            S_EVAL: begin
                if (i_status.goal_reached) begin
                    n_state = S_STOP;
                end else begin
                    cmd.eval = 1'b1;
                    n_state = S_MUL;
                end
            end
            S_STOP: begin
                if (i_status.out_free) begin
                    cmd.emit_stop = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_MUL: begin
                cmd.mul = 1'b1;
                n_state = S_SUM;
            end
            S_SUM: begin
                cmd.sum = 1'b1;
                n_chan  = 1'b0;
                n_state = S_SCALE;
            end
            S_SCALE: begin
                cmd.scale = 1'b1;
                n_cnt   = CNT_W'(Q_W - 1);
                n_state = S_DIV;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_NEXT;
                end
            end
            S_NEXT: begin
                if (!r_chan) begin
                    cmd.hold_first = 1'b1;
                    n_chan  = 1'b1;
                    n_state = S_SCALE;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    cmd.emit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_chan  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_chan  <= n_chan;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_cmd      = cmd;

endmodule

@@ hdl/tsd_dp.sv @@
module tsd_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  tsd_pkg::t_cfg                     i_cfg,
    input  tsd_pkg::t_cmd                     i_cmd,
    input  logic        [tsd_pkg::POS_W-1:0]  i_target_distance,
    input  logic signed [tsd_pkg::PEAK_W-1:0] i_peak_power,
    input  logic        [tsd_pkg::POS_W-1:0]  i_left_position,
    input  logic        [tsd_pkg::POS_W-1:0]  i_right_position,
    output tsd_pkg::t_status                  o_status,
    tsd_out_if.source                         o_out
);
    import tsd_pkg::*;

    // move state
    logic             r_active;
    logic [POS_W-1:0] r_goal;
    logic [PWR_W-1:0] r_peak;
    logic             r_backward;
    logic             r_in_decel;
    logic [POS_W-1:0] r_entry;

    // per-tick working registers
    logic [POS_W-1:0]   r_left, r_right;
    logic [PWR_W-1:0]   r_base, r_slope;
    logic               r_slope_neg;
    logic [POS_W-1:0]   r_den, r_x;
    logic [PHASE_W-1:0] r_phase;
    logic [FAC_W-1:0]   r_f_left, r_f_right;
    logic [PROD_W-1:0]  r_p1, r_p2, r_num, r_div;
    logic [REM_W-1:0]   r_rem, r_dsh;
    logic [Q_W-1:0]     r_q, r_q_first;

    // output register
    logic                     r_out_valid;
    logic signed [DRV_W-1:0]  r_first, r_second;
    logic                     r_stopped;
    logic [PHASE_W-1:0]       r_out_phase;

    logic [PEAK_W-1:0]        abs_peak;
    logic [PWR_W-1:0]         sp, ep;
    logic signed [POS_W+1:0]  cruise_end;
    logic                     is_accel, is_cruise;
    logic [POS_W-1:0]         entry_eff;
    logic signed [POS_W:0]    diff;
    logic signed [POS_W+1:0]  fl_raw, fr_raw;
    logic [PWR_W-1:0]         e_base, e_slope;
    logic                     e_neg;
    logic [POS_W-1:0]         e_den, e_x;
    logic [PHASE_W-1:0]       e_phase;
    logic [FAC_W-1:0]         fac;
    logic [DRV_W-1:0]         mag1, mag2;
    logic                     out_free;

    function automatic logic [FAC_W-1:0] clamp_fac(input logic signed [POS_W+1:0] v);
        logic [FAC_W-1:0] r;
        if (v < (POS_W+2)'(FAC_LO)) begin
            r = FAC_W'(FAC_LO);
        end else if (v > (POS_W+2)'(FAC_HI)) begin
            r = FAC_W'(FAC_HI);
        end else begin
            r = v[FAC_W-1:0];
        end
        return r;
    endfunction

    assign abs_peak = i_peak_power[PEAK_W-1] ? PEAK_W'(-i_peak_power) : PEAK_W'(i_peak_power);
    assign sp       = sat_pwr(PEAK_W'(i_cfg.start_power));
    assign ep       = sat_pwr(PEAK_W'(i_cfg.end_power));

    assign cruise_end = $signed({2'b00, r_goal})
                      - $signed({2'b00, i_cfg.ramp_up_length})
                      - $signed({2'b00, i_cfg.ramp_down_length});
    assign is_accel  = !r_in_decel && (r_left < i_cfg.ramp_up_length);
    assign is_cruise = !r_in_decel && !is_accel && ($signed({2'b00, r_left}) < cruise_end);
    assign entry_eff = r_in_decel ? r_entry : r_left;

    assign diff   = $signed({1'b0, r_left}) - $signed({1'b0, r_right});
    assign fl_raw = (POS_W+2)'(FAC_NOM) - (POS_W+2)'(diff);
    assign fr_raw = (POS_W+2)'(FAC_NOM) + (POS_W+2)'(diff);

    always_comb begin
        if (is_accel) begin
            e_phase = PH_ACCEL;
            e_base  = sp;
            e_den   = i_cfg.ramp_up_length;
            e_x     = r_left;
            e_neg   = (r_peak < sp);
            e_slope = (r_peak >= sp) ? r_peak - sp : sp - r_peak;
        end else if (is_cruise) begin
            e_phase = PH_CRUISE;
            e_base  = r_peak;
            e_den   = POS_W'(1);
            e_x     = '0;
            e_neg   = 1'b0;
            e_slope = '0;
        end else begin
            e_phase = PH_DECEL;
            e_base  = r_peak;
            e_den   = r_goal - entry_eff;
            e_x     = (r_left < entry_eff) ? '0 : r_left - entry_eff;
            e_neg   = (ep < r_peak);
            e_slope = (ep >= r_peak) ? ep - r_peak : r_peak - ep;
        end
    end

    assign fac      = i_cmd.chan ? r_f_right : r_f_left;
    assign out_free = !r_out_valid || o_out.ready;
    assign mag1     = DRV_W'(r_q_first);
    assign mag2     = DRV_W'(r_q);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active   <= 1'b0;
            r_goal     <= '0;
            r_peak     <= '0;
            r_backward <= 1'b0;
            r_in_decel <= 1'b0;
            r_entry    <= '0;
        end else begin
            if (i_cmd.start) begin
                r_active   <= 1'b1;
                r_goal     <= i_target_distance;
                r_peak     <= sat_pwr(abs_peak);
                r_backward <= i_peak_power[PEAK_W-1];
                r_in_decel <= 1'b0;
                r_entry    <= '0;
            end
            if (i_cmd.eval && !is_accel && !is_cruise && !r_in_decel) begin
                r_in_decel <= 1'b1;
                r_entry    <= r_left;
            end
            if (i_cmd.emit_stop) begin
                r_active <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.tick_load) begin
            r_left  <= i_left_position;
            r_right <= i_right_position;
        end
        if (i_cmd.eval) begin
            r_phase     <= e_phase;
            r_base      <= e_base;
            r_slope     <= e_slope;
            r_slope_neg <= e_neg;
            r_den       <= e_den;
            r_x         <= e_x;
            r_f_left    <= clamp_fac(fl_raw);
            r_f_right   <= clamp_fac(fr_raw);
        end
        if (i_cmd.mul) begin
            r_p1 <= PROD_W'(r_base) * PROD_W'(r_den);
            r_p2 <= PROD_W'(r_slope) * PROD_W'(r_x);
        end
        if (i_cmd.sum) begin
            r_num <= r_slope_neg ? r_p1 - r_p2 : r_p1 + r_p2;
            r_div <= PROD_W'(r_den) * PROD_W'(DEN_SCALE);
        end
        if (i_cmd.scale) begin
            r_rem <= REM_W'(r_num) * REM_W'(fac) + REM_W'(r_div >> 1);
            r_dsh <= REM_W'(r_div) << (Q_W - 1);
            r_q   <= '0;
        end
        if (i_cmd.div_step) begin
            if (r_rem >= r_dsh) begin
                r_rem <= r_rem - r_dsh;
                r_q   <= {r_q[Q_W-2:0], 1'b1};
            end else begin
                r_q   <= {r_q[Q_W-2:0], 1'b0};
            end
            r_dsh <= r_dsh >> 1;
        end
        if (i_cmd.hold_first) begin
            r_q_first <= r_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit || i_cmd.emit_stop) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_stop) begin
            r_first     <= '0;
            r_second    <= '0;
            r_stopped   <= 1'b1;
            r_out_phase <= PH_STOP;
        end else if (i_cmd.emit) begin
            r_first     <= r_backward ? $signed(mag1) : $signed(DRV_W'(0) - mag1);
            r_second    <= r_backward ? $signed(DRV_W'(0) - mag2) : $signed(mag2);
            r_stopped   <= 1'b0;
            r_out_phase <= r_phase;
        end
    end

    assign o_status.active       = r_active;
    assign o_status.goal_reached = (r_left >= r_goal);
    assign o_status.out_free     = out_free;

    assign o_out.valid        = r_out_valid;
    assign o_out.first_drive  = r_first;
    assign o_out.second_drive = r_second;
    assign o_out.stopped      = r_stopped;
    assign o_out.phase        = r_out_phase;

endmodule

@@ hdl/trapezoidal_straight_drive.sv @@
// trapezoidal straight-drive power profile
// i_cfg: register writes (start/end power, ramp up/down length), always
//   ready; user must write only with no move request in flight, unchecked
// i_in: kind 0 loads target distance and signed peak power, no result;
//   kind 1 is an encoder tick, one result while a move is active, none
//   while idle
// o_out: signed drive pair in thousandths, stopped flag and phase
// a tick runs eval, multiply and sum; then one multiply-add and an 11-step
//   shared restoring divider run per channel, two channels in turn, then
//   emit; a stop result follows eval; both wait for a free output register
// ticks are taken one at a time; start requests every cycle while idle
// i_in.ready is high only while the controller is idle
// a stalled receiver holds the result in the output register; the block
//   waits before writing the next result, so nothing is lost
// reset: registers return to their default values and any move is dropped
module trapezoidal_straight_drive (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tsd_cfg_if.sink   i_cfg,
    tsd_in_if.sink    i_in,
    tsd_out_if.source o_out
);
    import tsd_pkg::*;

    t_cfg    cfg;
    t_cmd    cmd;
    t_status status;
    logic    in_ready;

    assign i_in.ready = in_ready;

    tsd_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    tsd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_kind  (i_in.kind),
        .i_status   (status),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    tsd_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (cfg),
        .i_cmd             (cmd),
        .i_target_distance (i_in.target_distance),
        .i_peak_power      (i_in.peak_power),
        .i_left_position   (i_in.left_position),
        .i_right_position  (i_in.right_position),
        .o_status          (status),
        .o_out             (o_out)
    );

endmodule

@@ hdl/tsd_checker.sv @@
module tsd_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_out_valid,
    input  logic                              i_out_ready,
    input  logic signed [tsd_pkg::DRV_W-1:0]  i_first_drive,
    input  logic signed [tsd_pkg::DRV_W-1:0]  i_second_drive,
    input  logic                              i_stopped,
    input  logic        [tsd_pkg::PHASE_W-1:0] i_phase
);
    import tsd_pkg::*;

    assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_first_drive)
            && $stable(i_second_drive) && $stable(i_stopped) && $stable(i_phase))
        else $error("stalled result changed");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_stopped |-> i_first_drive == '0 && i_second_drive == '0
            && i_phase == PH_STOP)
        else $error("stop result malformed");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_stopped |-> i_phase != PH_STOP)
        else $error("stop phase without stop flag");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_first_drive >= -DRV_W'(FAC_HI) && i_first_drive <= DRV_W'(FAC_HI)
            && i_second_drive >= -DRV_W'(FAC_HI) && i_second_drive <= DRV_W'(FAC_HI))
        else $error("drive out of range");

endmodule

bind trapezoidal_straight_drive tsd_checker u_tsd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_first_drive  (o_out.first_drive),
    .i_second_drive (o_out.second_drive),
    .i_stopped      (o_out.stopped),
    .i_phase        (o_out.phase)
);

@@ verif/tb_trapezoidal_straight_drive.sv @@
module tb_trapezoidal_straight_drive;
    timeunit 1ns;
    timeprecision 1ps;

    import tsd_pkg::*;

    localparam logic KIND_START = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    localparam int SETTLE_CYCLES = 40;
    localparam int DRAIN_LIMIT   = 1000;
    localparam int LONG_HOLD     = 500;

    typedef struct packed {
        logic                     kind;
        logic [POS_W-1:0]         target;
        logic signed [PEAK_W-1:0] peak;
        logic [POS_W-1:0]         left_pos;
        logic [POS_W-1:0]         right_pos;
    } t_move_req;

    typedef struct packed {
        logic signed [DRV_W-1:0] first;
        logic signed [DRV_W-1:0] second;
        logic                    stopped;
        logic [PHASE_W-1:0]      phase;
    } t_drive;

    logic i_clk;
    logic i_rst_n;

    tsd_cfg_if cfg_if ();
    tsd_in_if  in_if ();
    tsd_out_if out_if ();

    trapezoidal_straight_drive u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    t_move_req   pending_requests[$];
    t_drive      expected_drives[$];
    int unsigned reqs_made;
    int unsigned reqs_taken;
    int unsigned drives_seen;
    int unsigned mismatches;

    // profile registers and move state as the block should hold them
    t_cfg   profile_regs;
    bit     mv_active;
    bit     mv_backward;
    bit     mv_decel;
    longint mv_goal;
    longint mv_peak;
    longint mv_entry;

    t_move_req   cur_req;
    bit          launch;
    int unsigned in_gap;
    int unsigned in_burst;
    int unsigned out_stall;
    int unsigned out_burst;
    t_drive      seen_drive;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #1_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic flag_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatches++;
    endtask

    function automatic longint pct_cap(input longint p);
        return (p > longint'(PWR_MAX)) ? longint'(PWR_MAX) : p;
    endfunction

    function automatic longint trim_factor(input longint f);
        if (f < FAC_LO)
            return FAC_LO;
        if (f > FAC_HI)
            return FAC_HI;
        return f;
    endfunction

    task automatic predict_drive(input t_move_req req);
        t_drive want;
        longint pos, rpos, sp, ep, pk, up, down, num, den, run, cruise_end;
        longint diff, m_first, m_second;
        if (req.kind == KIND_START) begin
            pk = $signed(req.peak);
            mv_backward = (pk < 0);
            mv_peak = pct_cap(pk < 0 ? -pk : pk);
            mv_goal = req.target;
            mv_decel = 1'b0;
            mv_entry = 0;
            mv_active = 1'b1;
        end else if (mv_active) begin
            pos = req.left_pos;
            rpos = req.right_pos;
            if (pos >= mv_goal) begin
                mv_active = 1'b0;
                want.first = '0;
                want.second = '0;
                want.stopped = 1'b1;
                want.phase = PH_STOP;
                expected_drives.push_back(want);
            end else begin
                sp = pct_cap(profile_regs.start_power);
                ep = pct_cap(profile_regs.end_power);
                up = profile_regs.ramp_up_length;
                down = profile_regs.ramp_down_length;
                pk = mv_peak;
                cruise_end = mv_goal - up - down;
                if (!mv_decel && pos < up) begin
                    want.phase = PH_ACCEL;
                    den = up;
                    num = sp * den + (pk - sp) * pos;
                end else if (!mv_decel && pos < cruise_end) begin
                    want.phase = PH_CRUISE;
                    den = 1;
                    num = pk;
                end else begin
                    if (!mv_decel) begin
                        mv_decel = 1'b1;
                        mv_entry = pos;
                    end
                    want.phase = PH_DECEL;
                    run = (pos < mv_entry) ? 0 : pos - mv_entry;
                    den = mv_goal - mv_entry;
                    num = pk * den + (ep - pk) * run;
                end
                diff = pos - rpos;
                m_first = (num * trim_factor(FAC_NOM - diff) + den * DEN_SCALE / 2)
                          / (den * DEN_SCALE);
                m_second = (num * trim_factor(FAC_NOM + diff) + den * DEN_SCALE / 2)
                           / (den * DEN_SCALE);
                want.first = DRV_W'(mv_backward ? m_first : -m_first);
                want.second = DRV_W'(mv_backward ? -m_second : m_second);
                want.stopped = 1'b0;
                expected_drives.push_back(want);
            end
        end
    endtask

    task automatic check_drive(input t_drive got);
        t_drive want;
        if (expected_drives.size() == 0) begin
            flag_mismatch($sformatf("unexpected result first=%0d second=%0d stopped=%0d phase=%0d",
                                    $signed(got.first), $signed(got.second), got.stopped,
                                    got.phase));
            return;
        end
        want = expected_drives.pop_front();
        if (got.first !== want.first)
            flag_mismatch($sformatf("result %0d first_drive %0d, want %0d", drives_seen,
                                    $signed(got.first), $signed(want.first)));
        if (got.second !== want.second)
            flag_mismatch($sformatf("result %0d second_drive %0d, want %0d", drives_seen,
                                    $signed(got.second), $signed(want.second)));
        if (got.stopped !== want.stopped)
            flag_mismatch($sformatf("result %0d stopped %0b, want %0b", drives_seen,
                                    got.stopped, want.stopped));
        if (got.phase !== want.phase)
            flag_mismatch($sformatf("result %0d phase %0d, want %0d", drives_seen,
                                    got.phase, want.phase));
    endtask

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            in_gap = 0;
            in_burst = 0;
        end else begin
            launch = 1'b0;
            if (in_if.valid && in_if.ready) begin
                predict_drive(cur_req);
                reqs_taken++;
                if (in_burst == 0 && $urandom_range(0, 39) == 0)
                    in_burst = $urandom_range(10, 30);
                if (in_burst > 0) begin
                    in_burst--;
                    in_gap = 0;
                end else begin
                    in_gap = $urandom_range(0, 4);
                end
            end else if (!in_if.valid && in_gap > 0) begin
                in_gap--;
            end
            if ((!in_if.valid || in_if.ready) && in_gap == 0 && pending_requests.size() != 0)
                launch = 1'b1;
            if (launch) begin
                cur_req = pending_requests.pop_front();
                in_if.valid           <= 1'b1;
                in_if.kind            <= cur_req.kind;
                in_if.target_distance <= cur_req.target;
                in_if.peak_power      <= cur_req.peak;
                in_if.left_position   <= cur_req.left_pos;
                in_if.right_position  <= cur_req.right_pos;
            end else if (in_if.valid && in_if.ready) begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            out_stall = 0;
            out_burst = 0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                seen_drive.first = out_if.first_drive;
                seen_drive.second = out_if.second_drive;
                seen_drive.stopped = out_if.stopped;
                seen_drive.phase = out_if.phase;
                check_drive(seen_drive);
                drives_seen++;
                if (out_burst == 0 && $urandom_range(0, 39) == 0)
                    out_burst = $urandom_range(10, 30);
                // long back-pressure so the block fills and stalls its input
                if (drives_seen == 150 || drives_seen == 600) begin
                    out_stall = LONG_HOLD;
                end else if (out_burst > 0) begin
                    out_burst--;
                    out_stall = 0;
                end else begin
                    out_stall = $urandom_range(0, 4);
                end
            end else if (out_stall > 0) begin
                out_stall--;
            end
            out_if.ready <= (out_stall == 0);
        end
    end

    task automatic push_request(input t_move_req r);
        pending_requests.push_back(r);
        reqs_made++;
    endtask

    task automatic make_start(input int target, input int peak);
        t_move_req r;
        r.kind = KIND_START;
        r.target = POS_W'(target);
        r.peak = PEAK_W'(peak);
        r.left_pos = POS_W'($urandom);
        r.right_pos = POS_W'($urandom);
        push_request(r);
    endtask

    task automatic make_tick(input int left_pos, input int right_pos);
        t_move_req r;
        r.kind = KIND_TICK;
        r.target = POS_W'($urandom);
        r.peak = PEAK_W'($urandom);
        r.left_pos = POS_W'(left_pos);
        r.right_pos = POS_W'(right_pos);
        push_request(r);
    endtask

    function automatic int right_for(input int pos);
        int skew;
        if ($urandom_range(0, 15) == 0)
            return $urandom_range(0, 65535);
        skew = $urandom_range(0, 300);
        return pos + skew - 150;
    endfunction

    task automatic queue_move(input int span_hi);
        int goal, stride, pos, guard;
        bit abandon;
        goal = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535)
                                           : $urandom_range(0, span_hi);
        make_start(goal, $urandom);
        stride = goal / $urandom_range(2, 24) + 1;
        pos = ($urandom_range(0, 3) == 0) ? $urandom_range(0, stride) : 0;
        guard = 0;
        abandon = 1'b0;
        while (pos < goal && guard < 60 && !abandon) begin
            make_tick(pos, right_for(pos));
            guard++;
            // encoder slip backward now and then
            if ($urandom_range(0, 15) == 0 && pos > stride)
                pos -= $urandom_range(1, stride);
            else
                pos += $urandom_range(1, 2 * stride);
            if ($urandom_range(0, 11) == 0)
                abandon = 1'b1;
        end
        if (!abandon) begin
            if (pos > 65535)
                pos = 65535;
            make_tick(pos, right_for(pos));
        end
        if ($urandom_range(0, 3) == 0)
            make_tick($urandom, $urandom);
    endtask

    task automatic random_phase(input int unsigned n_items, input int span_hi);
        int unsigned stop_at;
        t_move_req r;
        stop_at = reqs_made + n_items;
        while (reqs_made < stop_at) begin
            if ($urandom_range(0, 9) == 0) begin
                r = t_move_req'({$urandom, $urandom});
                push_request(r);
            end else begin
                queue_move(span_hi);
            end
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do
            @(posedge i_clk);
        while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        case (idx)
            REG_START_POWER: profile_regs.start_power = val[PWR_W-1:0];
            REG_END_POWER:   profile_regs.end_power = val[PWR_W-1:0];
            REG_RAMP_UP:     profile_regs.ramp_up_length = val[POS_W-1:0];
            REG_RAMP_DOWN:   profile_regs.ramp_down_length = val[POS_W-1:0];
            default: ;
        endcase
    endtask

    task automatic load_profile(input int sp, input int ep, input int up, input int down);
        write_reg(REG_START_POWER, CFG_DATA_W'(sp));
        write_reg(REG_END_POWER, CFG_DATA_W'(ep));
        write_reg(REG_RAMP_UP, CFG_DATA_W'(up));
        write_reg(REG_RAMP_DOWN, CFG_DATA_W'(down));
    endtask

    // wait until every request is taken and every result is back
    task automatic drain();
        int unsigned waited;
        while (reqs_taken != reqs_made)
            @(posedge i_clk);
        waited = 0;
        while (expected_drives.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (expected_drives.size() != 0) begin
            flag_mismatch($sformatf("%0d results never arrived", expected_drives.size()));
            expected_drives.delete();
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.index = '0;
        cfg_if.data = '0;
        in_if.valid = 1'b0;
        in_if.kind = KIND_START;
        in_if.target_distance = '0;
        in_if.peak_power = '0;
        in_if.left_position = '0;
        in_if.right_position = '0;
        out_if.ready = 1'b0;
        reqs_made = 0;
        reqs_taken = 0;
        drives_seen = 0;
        mismatches = 0;
        profile_regs.start_power = START_POWER_RST;
        profile_regs.end_power = END_POWER_RST;
        profile_regs.ramp_up_length = '0;
        profile_regs.ramp_down_length = '0;
        mv_active = 1'b0;
        mv_backward = 1'b0;
        mv_decel = 1'b0;
        mv_goal = 0;
        mv_peak = 0;
        mv_entry = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset profile, no ramps
        make_tick(100, 100);
        make_start(0, 50);
        make_tick(0, 0);
        make_start(65535, -128);
        make_tick(0, 65535);
        make_tick(65535, 65535);
        make_start(1000, 0);
        make_tick(500, 480);
        make_start(2000, 127);
        make_tick(1999, 2100);
        make_tick(2000, 2000);
        drain();

        // full trapezoid, slip in decel, decel entered early, ramp past goal
        load_profile(0, 100, 100, 100);
        make_start(1000, 60);
        make_tick(0, 0);
        make_tick(99, 120);
        make_tick(100, 100);
        make_tick(800, 790);
        make_tick(700, 700);
        make_tick(999, 1000);
        make_tick(1000, 1000);
        make_start(150, -30);
        make_tick(120, 118);
        make_tick(50, 50);
        make_tick(200, 0);
        make_start(50, 90);
        make_tick(10, 10);
        make_tick(60, 60);
        drain();

        load_profile(0, 0, 0, 0);
        random_phase(150, 3000);
        drain();
        load_profile(127, 127, 65535, 65535);
        random_phase(150, 3000);
        drain();
        load_profile(100, 5, $urandom_range(0, 500), $urandom_range(0, 500));
        random_phase(150, 2000);
        repeat (3) begin
            drain();
            load_profile($urandom_range(0, 127), $urandom_range(0, 127),
                         $urandom_range(0, 1500), $urandom_range(0, 1500));
            random_phase(150, 4000);
        end
        drain();
        load_profile($urandom_range(0, 100), $urandom_range(0, 100),
                     $urandom_range(0, 40000), $urandom_range(0, 40000));
        random_phase(150, 65535);
        drain();

        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ trapezoidal_straight_drive.f @@
hdl/tsd_pkg.sv
hdl/tsd_if.sv
hdl/tsd_regs.sv
hdl/tsd_ctrl.sv
hdl/tsd_dp.sv
hdl/trapezoidal_straight_drive.sv
hdl/tsd_checker.sv
verif/tb_trapezoidal_straight_drive.sv
